// ===== sv/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types, constants and helpers for the stream pattern replace unit.
// ----------------------------------------------------------------------------
package spr_pkg;

    // Sizes
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int BUF_DEPTH   = PATTERN_MAX + 1;   // held bytes plus the new byte
    localparam int LEN_W       = 4;
    localparam int COUNT_W     = 31;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // Input transaction
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    // Output transaction
    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               run_last;
        logic               text_done;
        logic [COUNT_W-1:0] replace_count;
        logic               pattern_error;
    } t_out;

    // Work handed from the matcher to the emitter for one input byte
    typedef struct packed {
        logic [BUF_DEPTH-1:0][7:0] pop_bytes;  // bytes released, oldest first
        logic [LEN_W-1:0]          pop_cnt;    // 0..PATTERN_MAX
        logic [LEN_W-1:0]          rep_cnt;    // replacement bytes to send
        logic                      done;       // end of text
        logic [COUNT_W-1:0]        count;
        logic                      error;
    } t_job;

    // Length register clamp
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] lim);
        clamp_len = (len > lim) ? lim : len;
    endfunction

endpackage

// ===== sv/spr_match.sv =====
// ----------------------------------------------------------------------------
// spr_match
// Partial-match buffer and single-pass matcher. For each byte it finds the
// oldest position from which the held bytes still form a pattern prefix,
// releases everything before it, detects a full match, flushes at text end.
// ----------------------------------------------------------------------------
module spr_match
    import spr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_in                   i_in,
    input  logic [CFG_W-1:0]      i_pat_bytes,
    input  logic [LEN_W-1:0]      i_pat_len,
    input  logic [LEN_W-1:0]      i_rep_len,
    output t_job                  o_job
);

    logic [7:0]         r_held [PATTERN_MAX];
    logic [7:0]         n_held [PATTERN_MAX];
    logic [LEN_W-1:0]   r_held_cnt, n_held_cnt;
    logic [COUNT_W-1:0] r_total, n_total;

    logic [7:0]         w [BUF_DEPTH];
    logic [LEN_W-1:0]   k;
    logic [BUF_DEPTH-1:0] ok;
    logic [LEN_W-1:0]   s_sel;
    logic [LEN_W-1:0]   keep;
    logic               found;
    logic               matched;
    logic [COUNT_W-1:0] total_inc;

    // Working buffer: held bytes with the new byte appended
    always_comb begin
        k = r_held_cnt + LEN_W'(1);
        for (int j = 0; j < PATTERN_MAX; j++) begin
            w[j] = (LEN_W'(j) < r_held_cnt) ? r_held[j] : i_in.text_byte;
        end
        w[PATTERN_MAX] = i_in.text_byte;
    end

    // Prefix test for every start position
    always_comb begin
        for (int s = 0; s < BUF_DEPTH; s++) begin
            ok[s] = (i_pat_len != '0) && (LEN_W'(s) < k) &&
                    ((k - LEN_W'(s)) <= i_pat_len);
            for (int j = 0; (j < PATTERN_MAX) && (s + j < BUF_DEPTH); j++) begin
                if ((LEN_W'(s + j) < k) && (w[s + j] != i_pat_bytes[8*j +: 8])) begin
                    ok[s] = 1'b0;
                end
            end
        end
    end

    // Oldest surviving start, match detect, count
    always_comb begin
        found = 1'b0;
        s_sel = k;
        for (int s = BUF_DEPTH - 1; s >= 0; s--) begin
            if (ok[s]) begin
                found = 1'b1;
                s_sel = LEN_W'(s);
            end
        end
        keep      = k - s_sel;
        matched   = found && (keep == i_pat_len);
        total_inc = (matched && (r_total != COUNT_MAX)) ? r_total + COUNT_W'(1) : r_total;
    end

    // Job and next state
    always_comb begin
        for (int j = 0; j < BUF_DEPTH; j++) begin
            o_job.pop_bytes[j] = w[j];
        end
        o_job.pop_cnt = (i_in.end_of_text && !matched) ? k : s_sel;
        o_job.rep_cnt = matched ? i_rep_len : '0;
        o_job.done    = i_in.end_of_text;
        o_job.error   = (i_pat_len == '0);
        o_job.count   = (i_pat_len == '0) ? '0 : total_inc;

        for (int j = 0; j < PATTERN_MAX; j++) begin
            n_held[j] = r_held[j];
            for (int s = 0; s < BUF_DEPTH - j; s++) begin
                if (s_sel == LEN_W'(s)) begin
                    n_held[j] = w[s + j];
                end
            end
        end
        n_held_cnt = (matched || i_in.end_of_text) ? '0 : keep;
        n_total    = i_in.end_of_text ? '0 : total_inc;
    end

    // Held bytes carry no reset; only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
            r_total    <= '0;
        end else if (i_load) begin
            r_held_cnt <= n_held_cnt;
            r_total    <= n_total;
        end
    end

endmodule

// ===== sv/spr_emit.sv =====
// ----------------------------------------------------------------------------
// spr_emit
// Result register: holds the job of one input byte and sends its released
// bytes, then its replacement bytes, one transaction per cycle when ready.
// ----------------------------------------------------------------------------
module spr_emit
    import spr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_job             i_job,
    input  logic [CFG_W-1:0] i_rep_bytes,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data
);

    logic                      r_active;
    logic [BUF_DEPTH-1:0][7:0] r_pop_q;
    logic [LEN_W-1:0]          r_pop_cnt;
    logic [LEN_W-1:0]          r_rep_rem;
    logic [2:0]                r_rep_pos;
    logic                      r_done;
    logic [COUNT_W-1:0]        r_count;
    logic                      r_error;

    logic [LEN_W:0]            remaining;
    logic                      run_last;
    logic                      take;

    // Output view of the head of the job
    always_comb begin
        remaining = {1'b0, r_pop_cnt} + {1'b0, r_rep_rem};
        run_last  = (remaining <= (LEN_W+1)'(1));
        take      = r_active && i_out_ready;
        o_free    = !r_active || (take && run_last);

        o_out_valid              = r_active;
        o_out_data.byte_valid    = (r_pop_cnt != '0) || (r_rep_rem != '0);
        if (r_pop_cnt != '0) begin
            o_out_data.out_byte = r_pop_q[0];
        end else if (r_rep_rem != '0) begin
            o_out_data.out_byte = i_rep_bytes[{r_rep_pos, 3'b000} +: 8];
        end else begin
            o_out_data.out_byte = 8'd0;
        end
        o_out_data.run_last      = run_last;
        o_out_data.text_done     = r_done && run_last;
        o_out_data.replace_count = (r_done && run_last) ? r_count : '0;
        o_out_data.pattern_error = r_done && run_last && r_error;
    end

    // Payload: load a new job or step through the current one
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pop_q   <= i_job.pop_bytes;
            r_pop_cnt <= i_job.pop_cnt;
            r_rep_rem <= i_job.rep_cnt;
            r_rep_pos <= '0;
            r_done    <= i_job.done;
            r_count   <= i_job.count;
            r_error   <= i_job.error;
        end else if (take) begin
            if (r_pop_cnt != '0) begin
                for (int j = 0; j < BUF_DEPTH - 1; j++) begin
                    r_pop_q[j] <= r_pop_q[j + 1];
                end
                r_pop_cnt <= r_pop_cnt - LEN_W'(1);
            end else if (r_rep_rem != '0) begin
                r_rep_rem <= r_rep_rem - LEN_W'(1);
                r_rep_pos <= r_rep_pos + 3'd1;
            end
        end
    end

    // Job valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_load) begin
            r_active <= (i_job.pop_cnt != '0) || (i_job.rep_cnt != '0) || i_job.done;
        end else if (take && run_last) begin
            r_active <= 1'b0;
        end
    end

endmodule

// ===== sv/stream_pattern_replace_unit.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_replace_unit
// Streaming find-and-replace of one configured pattern with a saturating
// replacement count.
// ----------------------------------------------------------------------------
// Text enters one byte per transaction and every leftmost, non-overlapping
// occurrence of the pattern (1 to 8 bytes) is replaced by the replacement
// (0 to 8 bytes). A byte passes through an input register, the matcher and
// the result register, and its first result is presented once its job is
// loaded into the result register. Bytes that could still start a match
// are held back and produce no output until the match is resolved. A byte
// that yields several results keeps the result register busy until all are
// taken; while each byte yields at most one result and the output is ready,
// the unit sustains one byte per cycle. The final byte of a text flushes
// the held bytes and its last result carries text_done, the count and the
// error flag (a zero pattern length passes text unchanged and flags an
// error). Configuration writes belong in idle periods.
// ----------------------------------------------------------------------------
module stream_pattern_replace_unit
    import spr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_pat_bytes;
    logic [LEN_W-1:0] r_pat_len;
    logic [CFG_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0] r_rep_len;

    logic             r_in_valid;
    t_in              r_in_data;

    logic             emit_free;
    logic             load;
    logic [LEN_W-1:0] pat_len;
    logic [LEN_W-1:0] rep_len;
    t_job             job;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES:      r_pat_bytes <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_pat_len   <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_rep_bytes <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rep_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp lengths to the buffer sizes
    always_comb begin
        pat_len = clamp_len(r_pat_len, LEN_W'(PATTERN_MAX));
        rep_len = clamp_len(r_rep_len, LEN_W'(REPLACE_MAX));
    end

    // Input register; a transaction moves on once the result register frees
    assign load       = r_in_valid && emit_free;
    assign o_in_ready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    spr_match u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_in        (r_in_data),
        .i_pat_bytes (r_pat_bytes),
        .i_pat_len   (pat_len),
        .i_rep_len   (rep_len),
        .o_job       (job)
    );

    spr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_job       (job),
        .i_rep_bytes (r_rep_bytes),
        .o_free      (emit_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
